// ===== rtl/ssci_pkg.sv =====
// Shared widths, codes and reset values for the spread-slot counter table.
`default_nettype none

package ssci_pkg;

  // Field widths.
  localparam int CNT_W   = 31;
  localparam int IDX_W   = 6;
  localparam int THR_W   = 10;
  localparam int SIZE_W  = 7;
  localparam int PLACE_W = 2;
  localparam int SUM_W   = 32;

  // Table geometry.
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int IDX_LIMIT       = 64;

  // Saturation value of a counter.
  localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

  // Reset value of the table size register.
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(2);

  // Action codes.
  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_INC  = 1'b1;

  // Write place codes reported with each result.
  localparam logic [PLACE_W-1:0] PLACE_NONE   = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_TARGET = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_SEEN   = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/ssci_if.sv =====
// Channel interfaces for requests, results and the configuration write.
`default_nettype none

// Request channel.
interface ssci_in_if;
  import ssci_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [CNT_W-1:0]  seen_max;
  logic [IDX_W-1:0]  seen_index;
  logic [THR_W-1:0]  thread_index;

  modport source (output valid, action, seen_max, seen_index, thread_index, input ready);
  modport sink   (input valid, action, seen_max, seen_index, thread_index, output ready);
endinterface

// Result channel.
interface ssci_out_if;
  import ssci_pkg::*;
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   max_value;
  logic [IDX_W-1:0]   max_index;
  logic [PLACE_W-1:0] write_place;

  modport source (output valid, max_value, max_index, write_place, input ready);
  modport sink   (input valid, max_value, max_index, write_place, output ready);
endinterface

// Configuration write channel for the table size register.
interface ssci_cfg_if;
  import ssci_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/spread_slot_conditional_increment_top.sv =====
// Top level of the spread-slot conditional-increment counter table.
`default_nettype none

// The block holds a table of 31-bit counters in a single-port-read,
// single-port-write memory with registered read data; every counter reads
// as zero after reset through per-entry valid bits, so no clearing pass runs.
// One request is worked on at a time. A read action streams the active
// entries through the memory read port and then hands off the result. An
// increment action first reduces the sum of seen index, seen maximum and
// thread number modulo the table size with a restoring divider that retires
// one bit a cycle, then reads the target slot and, if needed, the seen slot.
// A new request is taken while the previous result still waits on the
// output register. The table size register may be written only while the
// block is idle.
module spread_slot_conditional_increment_top #(
  parameter int MAX_ENTRIES = ssci_pkg::MAX_ENTRIES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  ssci_in_if.sink    in_bus,
  ssci_out_if.source out_bus,
  ssci_cfg_if.sink   cfg_bus
);
  import ssci_pkg::*;

  // Only the first entries up to the index limit are ever addressed.
  localparam int LIM   = (MAX_ENTRIES < IDX_LIMIT) ? MAX_ENTRIES : IDX_LIMIT;
  localparam int AW    = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int BCW   = $clog2(SUM_W);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RD_T  = 3'd3;
  localparam logic [2:0] S_CMP_T = 3'd4;
  localparam logic [2:0] S_RD_S  = 3'd5;
  localparam logic [2:0] S_CMP_S = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [SIZE_W-1:0]  size_cfg_r;
  logic [SIZE_W-1:0]  size_eff;

  // Latched request.
  logic               act_r;
  logic [CNT_W-1:0]   seen_max_r;
  logic [IDX_W-1:0]   seen_idx_r;

  // Divider.
  logic [SUM_W-1:0]   sum_r;
  logic [SIZE_W-1:0]  rem_r;
  logic [BCW-1:0]     bit_cnt_r;
  logic [SIZE_W:0]    rem_sh;
  logic [SIZE_W-1:0]  rem_nxt;

  // Scan.
  logic [SIZE_W-1:0]  addr_r;
  logic               pend_r;
  logic [SIZE_W-1:0]  pend_idx_r;
  logic [CNT_W-1:0]   best_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               scan_issue;

  // Target selection.
  logic [SIZE_W-1:0]  target_r;
  logic [SIZE_W-1:0]  target_c;
  logic [SIZE_W-1:0]  target_inc;
  logic [PLACE_W-1:0] place_r;
  logic [CNT_W-1:0]   next_val;

  // Counter memory and valid bits.
  logic [CNT_W-1:0]   mem [LIM];
  logic [LIM-1:0]     valid_r;
  logic [CNT_W-1:0]   mem_q_r;
  logic               rvalid_q_r;
  logic [CNT_W-1:0]   rd_val;
  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_raddr, mem_waddr;

  // Output register.
  logic               out_valid_r;
  logic [CNT_W-1:0]   out_max_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [PLACE_W-1:0] out_place_r;
  logic               out_load;
  logic               in_fire;

  // Effective table size, clamped to one through the entry limit.
  always_comb begin
    size_eff = size_cfg_r;
    if (size_cfg_r == '0) begin
      size_eff = SIZE_W'(1);
    end
    if (size_cfg_r > SIZE_W'(LIM)) begin
      size_eff = SIZE_W'(LIM);
    end
  end

  assign in_fire      = in_bus.valid && (state_r == S_IDLE);
  assign in_bus.ready = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  // One restoring division step.
  always_comb begin
    rem_sh  = {rem_r, sum_r[SUM_W-1]};
    rem_nxt = rem_sh[SIZE_W-1:0];
    if (rem_sh >= {1'b0, size_eff}) begin
      rem_nxt = SIZE_W'(rem_sh - {1'b0, size_eff});
    end
  end

  // Target slot from the remainder, stepped past the seen index.
  always_comb begin
    target_inc = rem_r + SIZE_W'(1);
    if (target_inc == size_eff) begin
      target_inc = '0;
    end
    if (size_eff < SIZE_W'(2)) begin
      target_c = '0;
    end else if (rem_r == {1'b0, seen_idx_r}) begin
      target_c = target_inc;
    end else begin
      target_c = rem_r;
    end
  end

  assign next_val   = (seen_max_r == CNT_TOP) ? CNT_TOP : seen_max_r + CNT_W'(1);
  assign rd_val     = rvalid_q_r ? mem_q_r : '0;
  assign scan_issue = (addr_r < size_eff);

  // Memory port control and next state.
  always_comb begin
    state_nxt = state_r;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = addr_r[AW-1:0];
    mem_waddr = target_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_bus.action == ACT_READ) ? S_SCAN : S_DIV;
        end
      end
      S_SCAN: begin
        mem_re = scan_issue;
        if (!scan_issue && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (bit_cnt_r == BCW'(SUM_W - 1)) begin
          state_nxt = S_RD_T;
        end
      end
      S_RD_T: begin
        mem_re    = 1'b1;
        mem_raddr = target_c[AW-1:0];
        state_nxt = S_CMP_T;
      end
      S_CMP_T: begin
        if (rd_val <= seen_max_r) begin
          mem_we    = 1'b1;
          state_nxt = S_DONE;
        end else if ({1'b0, seen_idx_r} < size_eff) begin
          state_nxt = S_RD_S;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD_S: begin
        mem_re    = 1'b1;
        mem_raddr = seen_idx_r[AW-1:0];
        state_nxt = S_CMP_S;
      end
      S_CMP_S: begin
        mem_waddr = seen_idx_r[AW-1:0];
        mem_we    = (rd_val == seen_max_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Counter memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= next_val;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // Valid bits, set on the first write to an entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rvalid_q_r <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rvalid_q_r <= valid_r[mem_raddr];
      end
    end
  end

  // Control state, configuration and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_cfg_r  <= TABLE_SIZE_RST;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_bus.valid) begin
        size_cfg_r <= cfg_bus.data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        pend_r <= scan_issue;
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_r      <= in_bus.action;
          seen_max_r <= in_bus.seen_max;
          seen_idx_r <= in_bus.seen_index;
          sum_r      <= SUM_W'(in_bus.seen_index) + SUM_W'(in_bus.seen_max)
                        + SUM_W'(in_bus.thread_index);
          rem_r      <= '0;
          bit_cnt_r  <= '0;
          addr_r     <= '0;
          place_r    <= PLACE_NONE;
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          addr_r <= addr_r + SIZE_W'(1);
        end
        pend_idx_r <= addr_r;
        // Entry zero seeds the maximum; later entries win only when larger.
        if (pend_r && (pend_idx_r == '0 || rd_val > best_r)) begin
          best_r     <= rd_val;
          best_idx_r <= pend_idx_r[IDX_W-1:0];
        end
      end
      S_DIV: begin
        sum_r     <= {sum_r[SUM_W-2:0], 1'b0};
        rem_r     <= rem_nxt;
        bit_cnt_r <= bit_cnt_r + BCW'(1);
      end
      S_RD_T: begin
        target_r <= target_c;
      end
      S_CMP_T: begin
        if (rd_val <= seen_max_r) begin
          place_r <= PLACE_TARGET;
        end
      end
      S_CMP_S: begin
        if (rd_val == seen_max_r) begin
          place_r <= PLACE_SEEN;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      if (act_r == ACT_READ) begin
        out_max_r   <= best_r;
        out_idx_r   <= best_idx_r;
        out_place_r <= PLACE_NONE;
      end else begin
        out_max_r   <= '0;
        out_idx_r   <= '0;
        out_place_r <= place_r;
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.max_value   = out_max_r;
  assign out_bus.max_index   = out_idx_r;
  assign out_bus.write_place = out_place_r;

endmodule

`default_nettype wire
